[rtl/core/messagepack_token_decoder_macros.svh]
// Assertion macros for the MessagePack token decoder
`ifndef MESSAGEPACK_TOKEN_DECODER_MACROS_SVH
`define MESSAGEPACK_TOKEN_DECODER_MACROS_SVH

// Implication checked on every clock edge outside reset
`define MPTD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Condition that must never hold outside reset
`define MPTD_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

[rtl/core/mptd_pkg.sv]
package mptd_pkg;

  // Token kinds on token_kind
  typedef enum logic [3:0] {
    TK_NIL   = 4'd0,
    TK_BOOL  = 4'd1,
    TK_UINT  = 4'd2,
    TK_SINT  = 4'd3,
    TK_F32   = 4'd4,
    TK_F64   = 4'd5,
    TK_STR   = 4'd6,
    TK_BIN   = 4'd7,
    TK_ARR   = 4'd8,
    TK_MAP   = 4'd9,
    TK_PAY   = 4'd10,
    TK_LONG  = 4'd11,
    TK_UNSUP = 4'd12
  } tk_t;

  // Parser phase, one-hot
  typedef enum logic [2:0] {
    PH_HEAD    = 3'b001,
    PH_FOLLOW  = 3'b010,
    PH_PAYLOAD = 3'b100
  } phase_t;

  localparam int unsigned LEN_W   = 32;
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned CNT_W   = 4;

  // Header bytes with fixed meaning
  localparam logic [7:0] HDR_NIL   = 8'hc0;
  localparam logic [7:0] HDR_FALSE = 8'hc2;
  localparam logic [7:0] HDR_TRUE  = 8'hc3;
  localparam logic [7:0] HDR_BIN8  = 8'hc4;
  localparam logic [7:0] HDR_BIN16 = 8'hc5;
  localparam logic [7:0] HDR_BIN32 = 8'hc6;
  localparam logic [7:0] HDR_F32   = 8'hca;
  localparam logic [7:0] HDR_F64   = 8'hcb;
  localparam logic [7:0] HDR_U8    = 8'hcc;
  localparam logic [7:0] HDR_U16   = 8'hcd;
  localparam logic [7:0] HDR_U32   = 8'hce;
  localparam logic [7:0] HDR_U64   = 8'hcf;
  localparam logic [7:0] HDR_S8    = 8'hd0;
  localparam logic [7:0] HDR_S16   = 8'hd1;
  localparam logic [7:0] HDR_S32   = 8'hd2;
  localparam logic [7:0] HDR_S64   = 8'hd3;
  localparam logic [7:0] HDR_STR8  = 8'hd9;
  localparam logic [7:0] HDR_STR16 = 8'hda;
  localparam logic [7:0] HDR_STR32 = 8'hdb;
  localparam logic [7:0] HDR_ARR16 = 8'hdc;
  localparam logic [7:0] HDR_ARR32 = 8'hdd;
  localparam logic [7:0] HDR_MAP16 = 8'hde;
  localparam logic [7:0] HDR_MAP32 = 8'hdf;

endpackage

[rtl/core/messagepack_token_decoder.sv]
// Channel   Direction  Handshake           Payload
// --------  ---------  ------------------  ------------------------------------
// input     in         in_valid/in_stall   in_byte
// output    out        out_valid/out_stall token_kind, token_value, last_payload
// config    in         cfg_wr_en           cfg_wr_data (payload_limit)
//
// One byte per cycle while in_stall is low: a byte waits in the input register and
// its token, if any, is written into the output register when the byte advances.
// Each byte takes a single combinational decode/shift-accumulate step.
// rst is synchronous: parser returns to header phase, payload_limit to all ones.
// in_stall rises only while the input register is full and a token waits
// under out_stall; bytes that make no token still need the output side free.

module messagepack_token_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  token_kind,
  output logic [63:0] token_value,
  output logic        last_payload,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);
  import mptd_pkg::*;

  // Configuration
  logic [LEN_W-1:0]   payload_limit;

  // Input register
  logic               s1_valid;
  logic [7:0]         s1_byte;
  logic               advance;

  // Parser state
  phase_t             phase, phase_next;
  tk_t                pending_kind, pending_kind_next;
  logic [CNT_W-1:0]   follow_bytes_left, follow_bytes_left_next;
  logic [CNT_W-1:0]   follow_total, follow_total_next;
  logic [VALUE_W-1:0] accumulator, accumulator_next;
  logic [LEN_W-1:0]   payload_left, payload_left_next;
  logic               skipping, skipping_next;

  // Token of the current byte
  logic               emit;
  tk_t                emit_kind;
  logic [VALUE_W-1:0] emit_value;
  logic               emit_last;

  // Length token helper signals
  logic               len_go;
  tk_t                len_kind;
  logic [LEN_W-1:0]   len_val;
  logic               len_too_long;

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      payload_limit <= '1;
    end else if (cfg_wr_en) begin
      payload_limit <= cfg_wr_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte <= in_byte;
    end
  end

  // Decode one byte against the parser state
  always_comb begin
    phase_next             = phase;
    pending_kind_next      = pending_kind;
    follow_bytes_left_next = follow_bytes_left;
    follow_total_next      = follow_total;
    accumulator_next       = accumulator;
    payload_left_next      = payload_left;
    skipping_next          = skipping;
    emit                   = 1'b0;
    emit_kind              = TK_NIL;
    emit_value             = '0;
    emit_last              = 1'b0;
    len_go                 = 1'b0;
    len_kind               = TK_STR;
    len_val                = '0;
    len_too_long           = 1'b0;

    unique case (phase)
      PH_FOLLOW: begin
        accumulator_next = {accumulator[VALUE_W-9:0], s1_byte};
        if (follow_bytes_left != '0) begin
          follow_bytes_left_next = follow_bytes_left - 1'b1;
        end
        if (follow_bytes_left_next == '0) begin
          phase_next = PH_HEAD;
          if (pending_kind == TK_STR || pending_kind == TK_BIN) begin
            len_go   = 1'b1;
            len_kind = pending_kind;
            len_val  = accumulator_next[LEN_W-1:0];
          end else begin
            emit      = 1'b1;
            emit_kind = pending_kind;
            emit_value = accumulator_next;
            // sign-extend short signed integers
            if (pending_kind == TK_SINT) begin
              case (follow_total)
                4'd1: emit_value = {{56{accumulator_next[7]}}, accumulator_next[7:0]};
                4'd2: emit_value = {{48{accumulator_next[15]}}, accumulator_next[15:0]};
                4'd4: emit_value = {{32{accumulator_next[31]}}, accumulator_next[31:0]};
                default: emit_value = accumulator_next;
              endcase
            end
          end
        end
      end

      PH_PAYLOAD: begin
        if (payload_left != '0) begin
          payload_left_next = payload_left - 1'b1;
        end
        emit_last = (payload_left_next == '0);
        if (emit_last) begin
          phase_next    = PH_HEAD;
          skipping_next = 1'b0;
        end
        if (!skipping) begin
          emit       = 1'b1;
          emit_kind  = TK_PAY;
          emit_value = {56'd0, s1_byte};
        end
      end

      default: begin
        // header byte; an unused phase code lands here too
        phase_next = PH_HEAD;
        if (!s1_byte[7]) begin
          emit       = 1'b1;
          emit_kind  = TK_UINT;
          emit_value = {56'd0, s1_byte};
        end else if (s1_byte[7:4] == 4'h8) begin
          emit       = 1'b1;
          emit_kind  = TK_MAP;
          emit_value = {60'd0, s1_byte[3:0]};
        end else if (s1_byte[7:4] == 4'h9) begin
          emit       = 1'b1;
          emit_kind  = TK_ARR;
          emit_value = {60'd0, s1_byte[3:0]};
        end else if (s1_byte[7:5] == 3'b101) begin
          len_go   = 1'b1;
          len_kind = TK_STR;
          len_val  = {27'd0, s1_byte[4:0]};
        end else if (s1_byte[7:5] == 3'b111) begin
          emit       = 1'b1;
          emit_kind  = TK_SINT;
          emit_value = {56'hff_ffff_ffff_ffff, s1_byte};
        end else begin
          // fixed headers: most start a follow-byte run, the others emit at once
          accumulator_next = '0;
          phase_next       = PH_FOLLOW;
          unique case (s1_byte)
            HDR_BIN8:  begin pending_kind_next = TK_BIN;  follow_total_next = 4'd1; end
            HDR_BIN16: begin pending_kind_next = TK_BIN;  follow_total_next = 4'd2; end
            HDR_BIN32: begin pending_kind_next = TK_BIN;  follow_total_next = 4'd4; end
            HDR_F32:   begin pending_kind_next = TK_F32;  follow_total_next = 4'd4; end
            HDR_F64:   begin pending_kind_next = TK_F64;  follow_total_next = 4'd8; end
            HDR_U8:    begin pending_kind_next = TK_UINT; follow_total_next = 4'd1; end
            HDR_U16:   begin pending_kind_next = TK_UINT; follow_total_next = 4'd2; end
            HDR_U32:   begin pending_kind_next = TK_UINT; follow_total_next = 4'd4; end
            HDR_U64:   begin pending_kind_next = TK_UINT; follow_total_next = 4'd8; end
            HDR_S8:    begin pending_kind_next = TK_SINT; follow_total_next = 4'd1; end
            HDR_S16:   begin pending_kind_next = TK_SINT; follow_total_next = 4'd2; end
            HDR_S32:   begin pending_kind_next = TK_SINT; follow_total_next = 4'd4; end
            HDR_S64:   begin pending_kind_next = TK_SINT; follow_total_next = 4'd8; end
            HDR_STR8:  begin pending_kind_next = TK_STR;  follow_total_next = 4'd1; end
            HDR_STR16: begin pending_kind_next = TK_STR;  follow_total_next = 4'd2; end
            HDR_STR32: begin pending_kind_next = TK_STR;  follow_total_next = 4'd4; end
            HDR_ARR16: begin pending_kind_next = TK_ARR;  follow_total_next = 4'd2; end
            HDR_ARR32: begin pending_kind_next = TK_ARR;  follow_total_next = 4'd4; end
            HDR_MAP16: begin pending_kind_next = TK_MAP;  follow_total_next = 4'd2; end
            HDR_MAP32: begin pending_kind_next = TK_MAP;  follow_total_next = 4'd4; end
            HDR_NIL: begin
              phase_next       = PH_HEAD;
              accumulator_next = accumulator;
              emit             = 1'b1;
              emit_kind        = TK_NIL;
            end
            HDR_FALSE: begin
              phase_next       = PH_HEAD;
              accumulator_next = accumulator;
              emit             = 1'b1;
              emit_kind        = TK_BOOL;
            end
            HDR_TRUE: begin
              phase_next       = PH_HEAD;
              accumulator_next = accumulator;
              emit             = 1'b1;
              emit_kind        = TK_BOOL;
              emit_value       = 64'd1;
            end
            default: begin
              // extension types and the never-used byte
              phase_next       = PH_HEAD;
              accumulator_next = accumulator;
              emit             = 1'b1;
              emit_kind        = TK_UNSUP;
              emit_value       = {56'd0, s1_byte};
            end
          endcase
          follow_bytes_left_next = (phase_next == PH_FOLLOW) ? follow_total_next
                                                               : follow_bytes_left;
          if (phase_next != PH_FOLLOW) begin
            pending_kind_next = pending_kind;
            follow_total_next = follow_total;
          end
        end
      end
    endcase

    // String/binary length: limit check and payload setup
    if (len_go) begin
      len_too_long = (len_kind == TK_STR) ? (len_val >= payload_limit)
                                          : (len_val > payload_limit);
      emit       = 1'b1;
      emit_kind  = len_too_long ? TK_LONG : len_kind;
      emit_value = {32'd0, len_val};
      if (len_val != '0) begin
        phase_next        = PH_PAYLOAD;
        payload_left_next = len_val;
        skipping_next     = len_too_long;
      end else begin
        phase_next        = PH_HEAD;
        payload_left_next = '0;
        skipping_next     = 1'b0;
      end
    end
  end

  // Parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HEAD;
      pending_kind      <= TK_NIL;
      follow_bytes_left <= '0;
      follow_total      <= '0;
      accumulator       <= '0;
      payload_left      <= '0;
      skipping          <= 1'b0;
    end else if (advance) begin
      phase             <= phase_next;
      pending_kind      <= pending_kind_next;
      follow_bytes_left <= follow_bytes_left_next;
      follow_total      <= follow_total_next;
      accumulator       <= accumulator_next;
      payload_left      <= payload_left_next;
      skipping          <= skipping_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= emit;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      token_kind   <= emit_kind;
      token_value  <= emit_value;
      last_payload <= emit_last;
    end
  end

  // Checks
`include "messagepack_token_decoder_macros.svh"

  `MPTD_ASSERT_IMP(a_last_on_payload, out_valid && last_payload, token_kind == TK_PAY,
                   "last mark on a non-payload token")
  `MPTD_ASSERT_IMP(a_stall_cause, in_stall, s1_valid && out_valid && out_stall,
                   "input stalled without a blocked token")
  `MPTD_ASSERT_NEVER(a_payload_count, phase == PH_PAYLOAD && payload_left == '0,
                     "payload phase with no bytes left")
  `MPTD_ASSERT_NEVER(a_follow_count, phase == PH_FOLLOW && follow_bytes_left == '0,
                     "follow phase with no bytes left")

endmodule

[verif/tb_messagepack_token_decoder.sv]
`timescale 1ns / 1ps

module tb_messagepack_token_decoder;
  import mptd_pkg::*;

  // Header bytes outside the package set
  localparam logic [7:0] HDR_FIXMAP   = 8'h80;
  localparam logic [7:0] HDR_FIXARR   = 8'h90;
  localparam logic [7:0] HDR_FIXSTR   = 8'ha0;
  localparam logic [7:0] HDR_NEGFIX   = 8'he0;
  localparam logic [7:0] HDR_NEVER    = 8'hc1;
  localparam logic [7:0] HDR_EXT8     = 8'hc7;
  localparam logic [7:0] HDR_FIXEXT1  = 8'hd4;

  localparam int unsigned WATCHDOG_CYCLES = 5000;
  localparam int unsigned DRAIN_CYCLES    = 6;
  localparam int unsigned PHASE_BYTES     = 80;

  typedef struct packed {
    tk_t         kind;
    logic [63:0] value;
    logic        last;
  } token_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  token_kind;
  logic [63:0] token_value;
  logic        last_payload;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = 32'h0;

  // Tokens predicted but not yet seen on the output
  token_t      pending_tokens[$];
  token_t      oldest_token;
  int unsigned mismatches = 0;
  int unsigned stream_bytes = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;

  // Decoder shadow state
  phase_t      pr_phase = PH_HEAD;
  tk_t         pr_kind = TK_NIL;
  logic [3:0]  pr_follow_left = '0;
  logic [3:0]  pr_follow_total = '0;
  logic [63:0] pr_acc = '0;
  logic [31:0] pr_pay_left = '0;
  logic        pr_skip = 1'b0;
  logic [31:0] pr_limit = 32'hffffffff;

  messagepack_token_decoder u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .token_kind   (token_kind),
    .token_value  (token_value),
    .last_payload (last_payload),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------
  // Token prediction
  // ---------------------------------------------------------------------

  function automatic void begin_follow(input tk_t kind, input logic [3:0] count);
    pr_phase        = PH_FOLLOW;
    pr_kind         = kind;
    pr_follow_left  = count;
    pr_follow_total = count;
    pr_acc          = '0;
  endfunction

  // String length must stay below the limit, binary length may reach it
  function automatic bit length_token(input tk_t kind, input logic [63:0] raw,
                                      output token_t t);
    logic [31:0] len;
    bit          too_long;
    len      = raw[31:0];
    too_long = (kind == TK_STR) ? (len >= pr_limit) : (len > pr_limit);
    pr_phase    = PH_HEAD;
    pr_skip     = 1'b0;
    pr_pay_left = '0;
    if (len != 0) begin
      pr_phase    = PH_PAYLOAD;
      pr_pay_left = len;
      pr_skip     = too_long;
    end
    t.kind  = too_long ? TK_LONG : kind;
    t.value = {32'd0, len};
    t.last  = 1'b0;
    return 1'b1;
  endfunction

  function automatic bit decode_byte(input logic [7:0] b, output token_t t);
    logic [63:0] v;
    int          bits;
    bit          quiet;
    bit          last;
    t = '0;
    // gathering big-endian follow bytes
    if (pr_phase == PH_FOLLOW) begin
      pr_acc = {pr_acc[55:0], b};
      if (pr_follow_left != 0) pr_follow_left = pr_follow_left - 1'b1;
      if (pr_follow_left != 0) return 1'b0;
      pr_phase = PH_HEAD;
      if (pr_kind == TK_STR || pr_kind == TK_BIN) return length_token(pr_kind, pr_acc, t);
      v    = pr_acc;
      bits = 8 * int'(pr_follow_total);
      if (pr_kind == TK_SINT && bits > 0 && bits < 64 && v[bits-1]) begin
        v = v | ({64{1'b1}} << bits);
      end
      t.kind  = pr_kind;
      t.value = v;
      return 1'b1;
    end
    // payload bytes, silent when the length was rejected
    if (pr_phase == PH_PAYLOAD) begin
      quiet = pr_skip;
      if (pr_pay_left != 0) pr_pay_left = pr_pay_left - 1'b1;
      last = (pr_pay_left == 0);
      if (last) begin
        pr_phase = PH_HEAD;
        pr_skip  = 1'b0;
      end
      if (quiet) return 1'b0;
      t.kind  = TK_PAY;
      t.value = {56'd0, b};
      t.last  = last;
      return 1'b1;
    end
    // header byte
    pr_phase = PH_HEAD;
    if (b < HDR_FIXMAP) begin
      t.kind  = TK_UINT;
      t.value = {56'd0, b};
      return 1'b1;
    end
    if (b < HDR_FIXARR) begin
      t.kind  = TK_MAP;
      t.value = {60'd0, b[3:0]};
      return 1'b1;
    end
    if (b < HDR_FIXSTR) begin
      t.kind  = TK_ARR;
      t.value = {60'd0, b[3:0]};
      return 1'b1;
    end
    if (b < HDR_NIL) return length_token(TK_STR, {59'd0, b[4:0]}, t);
    if (b >= HDR_NEGFIX) begin
      t.kind  = TK_SINT;
      t.value = {{56{1'b1}}, b};
      return 1'b1;
    end
    case (b)
      HDR_NIL: begin
        t.kind = TK_NIL;
        return 1'b1;
      end
      HDR_FALSE, HDR_TRUE: begin
        t.kind  = TK_BOOL;
        t.value = {63'd0, b == HDR_TRUE};
        return 1'b1;
      end
      HDR_BIN8:  begin_follow(TK_BIN, 4'd1);
      HDR_BIN16: begin_follow(TK_BIN, 4'd2);
      HDR_BIN32: begin_follow(TK_BIN, 4'd4);
      HDR_F32:   begin_follow(TK_F32, 4'd4);
      HDR_F64:   begin_follow(TK_F64, 4'd8);
      HDR_U8:    begin_follow(TK_UINT, 4'd1);
      HDR_U16:   begin_follow(TK_UINT, 4'd2);
      HDR_U32:   begin_follow(TK_UINT, 4'd4);
      HDR_U64:   begin_follow(TK_UINT, 4'd8);
      HDR_S8:    begin_follow(TK_SINT, 4'd1);
      HDR_S16:   begin_follow(TK_SINT, 4'd2);
      HDR_S32:   begin_follow(TK_SINT, 4'd4);
      HDR_S64:   begin_follow(TK_SINT, 4'd8);
      HDR_STR8:  begin_follow(TK_STR, 4'd1);
      HDR_STR16: begin_follow(TK_STR, 4'd2);
      HDR_STR32: begin_follow(TK_STR, 4'd4);
      HDR_ARR16: begin_follow(TK_ARR, 4'd2);
      HDR_ARR32: begin_follow(TK_ARR, 4'd4);
      HDR_MAP16: begin_follow(TK_MAP, 4'd2);
      HDR_MAP32: begin_follow(TK_MAP, 4'd4);
      default: begin
        // extension types and the never-used byte
        t.kind  = TK_UNSUP;
        t.value = {56'd0, b};
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // One input transaction; prediction runs at the accepting edge
  task automatic send_byte(input logic [7:0] b);
    token_t t;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_byte  = b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    stream_bytes++;
    if (decode_byte(b, t)) pending_tokens.push_back(t);
  endtask

  task automatic send_be(input logic [63:0] v, input int nb);
    int i;
    for (i = nb - 1; i >= 0; i--) send_byte(v[8*i +: 8]);
  endtask

  task automatic send_rand(input int unsigned n);
    repeat (n) send_byte(8'($urandom));
  endtask

  // Let the decoder go quiet with the output side open
  task automatic drain();
    int unsigned saved_stall;
    @(negedge clk);
    in_valid    = 1'b0;
    saved_stall = stall_pct;
    stall_pct   = 0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    stall_pct = saved_stall;
  endtask

  task automatic write_limit(input logic [31:0] v);
    drain();
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    @(posedge clk);
    pr_limit = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Output checking
  // ---------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_tokens.size() == 0) begin
        mismatches++;
        $display("%0t token: expected none actual kind %0d value %h last %b", $time,
                 token_kind, token_value, last_payload);
      end else begin
        oldest_token = pending_tokens.pop_front();
        if (token_kind !== oldest_token.kind) begin
          mismatches++;
          $display("%0t token_kind: expected %0d actual %0d", $time,
                   oldest_token.kind, token_kind);
        end
        if (token_value !== oldest_token.value) begin
          mismatches++;
          $display("%0t token_value: expected %h actual %h", $time,
                   oldest_token.value, token_value);
        end
        if (last_payload !== oldest_token.last) begin
          mismatches++;
          $display("%0t last_payload: expected %b actual %b", $time,
                   oldest_token.last, last_payload);
        end
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= WATCHDOG_CYCLES) begin
        $display("%0t watchdog expired", $time);
        $display("status: fail");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Single-byte items: fixints, nil, bools, fixmap/fixarray, unsupported
  task automatic test_single_byte_forms();
    send_byte(8'h00);
    send_byte(8'h7f);
    send_byte(HDR_NEGFIX);
    send_byte(8'hff);
    send_byte(HDR_NIL);
    send_byte(HDR_FALSE);
    send_byte(HDR_TRUE);
    send_byte(HDR_FIXMAP);
    send_byte(HDR_FIXMAP | 8'h0f);
    send_byte(HDR_FIXARR);
    send_byte(HDR_FIXARR | 8'h0f);
    send_byte(HDR_NEVER);
    send_byte(HDR_EXT8);
    send_byte(HDR_FIXEXT1 | 8'h04);
  endtask

  // Fixed-width numbers and container counts, mostly at their extremes
  task automatic test_fixed_width_numbers();
    send_byte(HDR_U8);    send_be(64'hff, 1);
    send_byte(HDR_U16);   send_be(64'h8000, 2);
    send_byte(HDR_U32);   send_be(64'hffffffff, 4);
    send_byte(HDR_U64);   send_be(64'hffffffff_ffffffff, 8);
    send_byte(HDR_S8);    send_be(64'h80, 1);
    send_byte(HDR_S16);   send_be(64'h7fff, 2);
    send_byte(HDR_S32);   send_be(64'h80000000, 4);
    send_byte(HDR_S64);   send_be(64'h80000000_00000000, 8);
    send_byte(HDR_F32);   send_be(64'hffffffff, 4);
    send_byte(HDR_F64);   send_be(64'h3ff00000_00000000, 8);
    send_byte(HDR_ARR16); send_be(64'hffff, 2);
    send_byte(HDR_ARR32); send_be(64'h00010000, 4);
    send_byte(HDR_MAP16); send_be(64'h0000, 2);
    send_byte(HDR_MAP32); send_be(64'hffffffff, 4);
  endtask

  // Strings and binaries under the reset limit, empty ones included
  task automatic test_strings_and_binaries();
    send_byte(HDR_FIXSTR);
    send_byte(HDR_FIXSTR | 8'h03);   send_rand(3);
    send_byte(HDR_FIXSTR | 8'h1f);   send_rand(31);
    send_byte(HDR_STR8);  send_be(64'd0, 1);
    send_byte(HDR_BIN16); send_be(64'd0, 2);
    send_byte(HDR_BIN8);  send_be(64'd2, 1); send_rand(2);
    send_byte(HDR_STR16); send_be(64'd5, 2); send_rand(5);
    send_byte(HDR_STR32); send_be(64'd3, 4); send_rand(3);
    send_byte(HDR_BIN32); send_be(64'd1, 4); send_rand(1);
  endtask

  // Limit edges: string strictly below, binary up to, silent skip
  task automatic test_length_limits();
    write_limit(32'd0);
    send_byte(HDR_BIN8); send_be(64'd0, 1);
    // too long with zero length skips nothing
    send_byte(HDR_STR8); send_be(64'd0, 1);
    send_byte(HDR_FIXSTR | 8'h02); send_rand(2);
    send_byte(8'h01);
    write_limit(32'd3);
    send_byte(HDR_BIN8); send_be(64'd3, 1); send_rand(3);
    send_byte(HDR_BIN8); send_be(64'd4, 1); send_rand(4);
    send_byte(HDR_STR8); send_be(64'd3, 1); send_rand(3);
    send_byte(HDR_FIXSTR | 8'h02); send_rand(2);
    write_limit(32'hffffffff);
    send_byte(HDR_BIN8); send_be(64'd255, 1); send_rand(255);
  endtask

  // Length choice that clusters around the limit now and then
  function automatic int unsigned pick_len(input int unsigned max_len);
    int          n;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15 && pr_limit <= 32'd301) n = int'(pr_limit) - 1 + int'($urandom_range(0, 2));
    else if (r < 25) n = 0;
    else if (r < 30) n = int'($urandom_range(0, max_len));
    else n = int'($urandom_range(1, 24));
    if (n < 0) n = 0;
    if (n > int'(max_len)) n = int'(max_len);
    return n;
  endfunction

  // One item with random content; ext and never-used headers are sent alone
  task automatic send_item();
    int unsigned n;
    int unsigned r;
    logic [7:0]  h;
    bit          as_str;
    as_str = $urandom_range(0, 1);
    case ($urandom_range(0, 11))
      0: send_byte(8'($urandom_range(0, 127)));
      1: send_byte(HDR_NEGFIX | 8'($urandom_range(0, 31)));
      2: begin
        r = $urandom_range(0, 2);
        send_byte(r == 0 ? HDR_NIL : (r == 1 ? HDR_FALSE : HDR_TRUE));
      end
      3: send_byte(HDR_FIXMAP | 8'($urandom_range(0, 31)));
      4: begin
        case ($urandom_range(0, 11))
          0:  begin h = HDR_U8;  n = 1; end
          1:  begin h = HDR_U16; n = 2; end
          2:  begin h = HDR_U32; n = 4; end
          3:  begin h = HDR_U64; n = 8; end
          4:  begin h = HDR_S8;  n = 1; end
          5:  begin h = HDR_S16; n = 2; end
          6:  begin h = HDR_S32; n = 4; end
          7:  begin h = HDR_S64; n = 8; end
          8:  begin h = HDR_F32; n = 4; end
          9:  begin h = HDR_F64; n = 8; end
          10: begin h = HDR_U64; n = 8; end
          default: begin h = HDR_S64; n = 8; end
        endcase
        send_byte(h);
        send_rand(n);
      end
      5: begin
        case ($urandom_range(0, 3))
          0: begin h = HDR_ARR16; n = 2; end
          1: begin h = HDR_ARR32; n = 4; end
          2: begin h = HDR_MAP16; n = 2; end
          default: begin h = HDR_MAP32; n = 4; end
        endcase
        send_byte(h);
        send_rand(n);
      end
      6: begin
        n = pick_len(31);
        send_byte(HDR_FIXSTR | 8'(n));
        send_rand(n);
      end
      7, 8: begin
        n = pick_len(255);
        send_byte(as_str ? HDR_STR8 : HDR_BIN8);
        send_be(64'(n), 1);
        send_rand(n);
      end
      9: begin
        n = pick_len(300);
        send_byte(as_str ? HDR_STR16 : HDR_BIN16);
        send_be(64'(n), 2);
        send_rand(n);
      end
      10: begin
        n = pick_len(300);
        send_byte(as_str ? HDR_STR32 : HDR_BIN32);
        send_be(64'(n), 4);
        send_rand(n);
      end
      default: begin
        r = $urandom_range(0, 8);
        if (r == 0) send_byte(HDR_NEVER);
        else if (r <= 3) send_byte(HDR_EXT8 + 8'(r - 1));
        else send_byte(HDR_FIXEXT1 + 8'(r - 4));
      end
    endcase
  endtask

  // Next byte from the decoder's current phase; noise headers keep lengths small
  task automatic random_step();
    bit sized;
    sized = (pr_kind == TK_STR || pr_kind == TK_BIN);
    case (pr_phase)
      PH_FOLLOW: begin
        if (sized && pr_follow_left > 1) send_byte(8'h00);
        else if (sized) send_byte(8'($urandom_range(0, 40)));
        else send_byte(8'($urandom));
      end
      PH_PAYLOAD: send_byte(8'($urandom));
      default: begin
        if ($urandom_range(0, 99) < 10) send_byte(8'($urandom));
        else send_item();
      end
    endcase
  endtask

  // Random streams across idle modes and limit settings
  task automatic test_random_streams();
    int          p;
    logic [31:0] lim;
    for (p = 0; p < 8; p++) begin
      case (p)
        0: lim = $urandom_range(1, 40);
        1: lim = 32'd0;
        2: lim = 32'hffffffff;
        3: lim = $urandom_range(2, 60);
        4: lim = $urandom;
        5: lim = 32'd1;
        6: lim = $urandom_range(1, 300);
        default: lim = 32'hffffffff;
      endcase
      write_limit(lim);
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 86; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 86; end
        default: begin send_idle_pct = 14; stall_pct = 14; end
      endcase
      stream_bytes = 0;
      while (stream_bytes < PHASE_BYTES) random_step();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_single_byte_forms();
    test_fixed_width_numbers();
    test_strings_and_binaries();
    test_length_limits();
    test_random_streams();
    drain();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
